[design/tlex_pkg.sv]
// Shared types, codes and helpers of the token lexer.
package tlex_pkg;

  localparam int MaxText  = 65536;
  localparam int LenCap   = (MaxText < 65536) ? MaxText : 65536;
  localparam int PosW     = 16;
  localparam int LenW     = 17;
  localparam int KindW    = 5;
  localparam int QDepth   = 4;
  localparam int QPtrW    = 2;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0, M_NUM = 3'd1, M_WORD = 3'd2, M_DQ = 3'd3,
    M_SQ = 3'd4, M_EQ = 3'd5, M_BANG = 3'd6, M_DROP = 3'd7
  } scan_mode_t;

  typedef enum logic [KindW-1:0] {
    K_END = 5'd0, K_COMMA = 5'd1, K_SEMI = 5'd2, K_LBRACE = 5'd3, K_RBRACE = 5'd4,
    K_LBRACK = 5'd5, K_RBRACK = 5'd6, K_LPAREN = 5'd7, K_RPAREN = 5'd8,
    K_PLUS = 5'd9, K_MINUS = 5'd10, K_PCT = 5'd11, K_STAR = 5'd12, K_SLASH = 5'd13,
    K_EQEQ = 5'd14, K_ASSIGN = 5'd15, K_NE = 5'd16, K_NOT = 5'd17,
    K_DQSTR = 5'd18, K_SQSTR = 5'd19, K_NUMBER = 5'd20, K_INT = 5'd21,
    K_LONG = 5'd22, K_BOOL = 5'd23, K_CHAR = 5'd24, K_STR = 5'd25,
    K_TRUE = 5'd26, K_FALSE = 5'd27, K_IDENT = 5'd28, K_ERROR = 5'd29
  } kind_t;

  // Character classes decided by the front part
  typedef enum logic [3:0] {
    C_ZERO, C_BLANK, C_PUNCT, C_EQ, C_BANG, C_DQ, C_SQ, C_DIGIT, C_ALPHA, C_OTHER
  } cclass_t;

  // One classified character handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    cclass_t    cls;
    kind_t      pkind;
  } qword_t;

  typedef struct packed {
    kind_t            kind;
    logic [PosW-1:0]  start;
    logic [LenW-1:0]  len;
    logic             last;
  } tok_t;

  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h2C: k = K_COMMA;   8'h3B: k = K_SEMI;
      8'h7B: k = K_LBRACE;  8'h7D: k = K_RBRACE;
      8'h5B: k = K_LBRACK;  8'h5D: k = K_RBRACK;
      8'h28: k = K_LPAREN;  8'h29: k = K_RPAREN;
      8'h2B: k = K_PLUS;    8'h2D: k = K_MINUS;
      8'h25: k = K_PCT;     8'h2A: k = K_STAR;
      8'h2F: k = K_SLASH;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

[design/tlex_if.sv]
// Valid/ready channel interface carrying one payload word.
interface tlex_if #(parameter type T = logic [7:0]) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/tlex_front.sv]
// Front part: accept characters, classify them and push into the queue.
module tlex_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_text_char,
  output logic              q_push,
  output tlex_pkg::qword_t  q_data,
  input  logic              q_full
);

  tlex_pkg::kind_t  pk;
  tlex_pkg::cclass_t cls;
  logic [7:0] c;

  assign c  = in_text_char;
  assign pk = tlex_pkg::punct_kind(c);

  // Classify the incoming character
  always_comb begin
    if (c == 8'h00) cls = tlex_pkg::C_ZERO;
    else if (c == 8'h20 || c == 8'h0A || c == 8'h09 || c == 8'h0D) cls = tlex_pkg::C_BLANK;
    else if (pk != tlex_pkg::K_END) cls = tlex_pkg::C_PUNCT;
    else if (c == 8'h3D) cls = tlex_pkg::C_EQ;
    else if (c == 8'h21) cls = tlex_pkg::C_BANG;
    else if (c == 8'h22) cls = tlex_pkg::C_DQ;
    else if (c == 8'h27) cls = tlex_pkg::C_SQ;
    else if (c >= 8'h30 && c <= 8'h39) cls = tlex_pkg::C_DIGIT;
    else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
      cls = tlex_pkg::C_ALPHA;
    else cls = tlex_pkg::C_OTHER;
  end

  assign in_ready    = !q_full;
  assign q_push      = in_valid && !q_full;
  assign q_data.ch   = c;
  assign q_data.cls  = cls;
  assign q_data.pkind = pk;

  property p_no_push_full;
    @(posedge clk) disable iff (!rst_n) !(q_push && q_full);
  endproperty
  a_no_push_full: assert property (p_no_push_full) else $error("push into full queue");

  property p_ready_tracks;
    @(posedge clk) disable iff (!rst_n) in_ready == !q_full;
  endproperty
  a_ready_tracks: assert property (p_ready_tracks) else $error("ready out of step with queue");

  property p_zero_class;
    @(posedge clk) disable iff (!rst_n) (c == 8'h00) |-> (cls == tlex_pkg::C_ZERO);
  endproperty
  a_zero_class: assert property (p_zero_class) else $error("zero byte misclassified");

endmodule

[design/tlex_queue.sv]
// Short FIFO between the front and back parts.
module tlex_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tlex_pkg::qword_t  push_data,
  output logic              full,
  output logic              avail,
  output tlex_pkg::qword_t  head,
  input  logic              pop
);

  tlex_pkg::qword_t mem_r [tlex_pkg::QDepth];
  logic [tlex_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [tlex_pkg::QPtrW:0]   cnt_r;

  assign full  = (cnt_r == (tlex_pkg::QPtrW+1)'(tlex_pkg::QDepth));
  assign avail = (cnt_r != '0);
  assign head  = mem_r[rp_r];

  // Store payload
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (tlex_pkg::QPtrW+1)'(push) - (tlex_pkg::QPtrW+1)'(pop);
    end
  end

  property p_no_underflow;
    @(posedge clk) disable iff (!rst_n) pop |-> avail;
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

  property p_cnt_bound;
    @(posedge clk) disable iff (!rst_n)
      cnt_r <= (tlex_pkg::QPtrW+1)'(tlex_pkg::QDepth);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("queue count overrun");

  property p_ptr_step;
    @(posedge clk) disable iff (!rst_n) (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1);
  endproperty
  a_ptr_step: assert property (p_ptr_step) else $error("queue count slip");

endmodule

[design/tlex_back.sv]
// Back part: scanner state machine that turns classified characters into tokens.
module tlex_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_avail,
  input  tlex_pkg::qword_t  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output tlex_pkg::tok_t    out_tok
);

  localparam logic [tlex_pkg::LenW-1:0] Cap = tlex_pkg::LenW'(tlex_pkg::LenCap);

  tlex_pkg::scan_mode_t mode_r, mode_nxt;
  logic [tlex_pkg::PosW-1:0] pos_r, pos_nxt;
  logic [tlex_pkg::PosW-1:0] pst_r, pst_nxt;
  logic [tlex_pkg::LenW-1:0] plen_r, plen_nxt;
  logic [39:0] wpre_r, wpre_nxt;

  // Output slots: up to two tokens per character
  tlex_pkg::tok_t s0_r, s1_r, t0, t1;
  logic v0_r, v1_r;
  logic [1:0] n_tok;

  logic [7:0] c;
  tlex_pkg::cclass_t cls;
  logic fall, adv;
  logic [tlex_pkg::LenW-1:0] plen_inc;
  logic [tlex_pkg::PosW:0] pos_inc;
  tlex_pkg::kind_t wkind;

  assign c   = q_head.ch;
  assign cls = q_head.cls;
  assign plen_inc = (plen_r < Cap) ? plen_r + 1'b1 : plen_r;
  assign pos_inc  = {1'b0, pos_r} + 1'b1;

  // Keyword match on the stored word prefix
  always_comb begin
    wkind = tlex_pkg::K_IDENT;
    if (plen_r == 17'd3 && wpre_r == 40'h696E74) wkind = tlex_pkg::K_INT;
    else if (plen_r == 17'd4 && wpre_r == 40'h6C6F6E67) wkind = tlex_pkg::K_LONG;
    else if (plen_r == 17'd4 && wpre_r == 40'h626F6F6C) wkind = tlex_pkg::K_BOOL;
    else if (plen_r == 17'd4 && wpre_r == 40'h63686172) wkind = tlex_pkg::K_CHAR;
    else if (plen_r == 17'd3 && wpre_r == 40'h737472) wkind = tlex_pkg::K_STR;
    else if (plen_r == 17'd4 && wpre_r == 40'h74727565) wkind = tlex_pkg::K_TRUE;
    else if (plen_r == 17'd5 && wpre_r == 40'h66616C7365) wkind = tlex_pkg::K_FALSE;
  end

  // Take a character when the output slots are empty, or only the first is full and drains this cycle
  assign adv   = q_avail && (!v0_r || (out_ready && !v1_r));
  assign q_pop = adv;

  // Next-state and token generation
  always_comb begin
    mode_nxt = mode_r; pst_nxt = pst_r; plen_nxt = plen_r; wpre_nxt = wpre_r;
    pos_nxt = pos_r;
    t0 = '0; t1 = '0; n_tok = 2'd0; fall = 1'b0;
    unique case (mode_r) inside
      tlex_pkg::M_DROP: ;
      tlex_pkg::M_DQ, tlex_pkg::M_SQ: begin
        if ((mode_r == tlex_pkg::M_DQ && cls == tlex_pkg::C_DQ) ||
            (mode_r == tlex_pkg::M_SQ && cls == tlex_pkg::C_SQ)) begin
          t0 = '{(mode_r == tlex_pkg::M_DQ) ? tlex_pkg::K_DQSTR : tlex_pkg::K_SQSTR,
                 pst_r, plen_inc, 1'b0};
          n_tok = 2'd1; mode_nxt = tlex_pkg::M_IDLE;
        end else if (cls == tlex_pkg::C_ZERO) begin
          t0 = '{(mode_r == tlex_pkg::M_DQ) ? tlex_pkg::K_DQSTR : tlex_pkg::K_SQSTR,
                 pst_r, plen_r, 1'b0};
          t1 = '{tlex_pkg::K_END, pos_r, 17'd1, 1'b0};
          n_tok = 2'd2;
        end else plen_nxt = plen_inc;
      end
      tlex_pkg::M_NUM: begin
        if (cls == tlex_pkg::C_DIGIT) plen_nxt = plen_inc;
        else begin
          t0 = '{tlex_pkg::K_NUMBER, pst_r, plen_r, 1'b0}; n_tok = 2'd1; fall = 1'b1;
        end
      end
      tlex_pkg::M_WORD: begin
        if (cls == tlex_pkg::C_DIGIT || cls == tlex_pkg::C_ALPHA) begin
          if (plen_r < 17'd5) wpre_nxt = {wpre_r[31:0], c};
          plen_nxt = plen_inc;
        end else begin
          t0 = '{wkind, pst_r, plen_r, 1'b0}; n_tok = 2'd1; fall = 1'b1;
        end
      end
      tlex_pkg::M_EQ, tlex_pkg::M_BANG: begin
        if (cls == tlex_pkg::C_EQ) begin
          t0 = '{(mode_r == tlex_pkg::M_EQ) ? tlex_pkg::K_EQEQ : tlex_pkg::K_NE,
                 pst_r, 17'd2, 1'b0};
          n_tok = 2'd1; mode_nxt = tlex_pkg::M_IDLE;
        end else begin
          t0 = '{(mode_r == tlex_pkg::M_EQ) ? tlex_pkg::K_ASSIGN : tlex_pkg::K_NOT,
                 pst_r, 17'd1, 1'b0};
          n_tok = 2'd1; fall = 1'b1;
        end
      end
      default: fall = 1'b1;
    endcase

    // Scan the character from idle when idle or after a finished token
    if (fall) begin
      mode_nxt = tlex_pkg::M_IDLE;
      case (cls) inside
        tlex_pkg::C_ZERO, tlex_pkg::C_PUNCT, tlex_pkg::C_OTHER: begin
          if (n_tok == 2'd0) begin
            t0 = '{tlex_pkg::K_END, pos_r, 17'd1, 1'b0};
            if (cls == tlex_pkg::C_PUNCT) t0.kind = q_head.pkind;
            if (cls == tlex_pkg::C_OTHER) t0.kind = tlex_pkg::K_ERROR;
          end else begin
            t1 = '{tlex_pkg::K_END, pos_r, 17'd1, 1'b0};
            if (cls == tlex_pkg::C_PUNCT) t1.kind = q_head.pkind;
            if (cls == tlex_pkg::C_OTHER) t1.kind = tlex_pkg::K_ERROR;
          end
          n_tok = n_tok + 2'd1;
          if (cls == tlex_pkg::C_OTHER) begin
            mode_nxt = tlex_pkg::M_DROP; pst_nxt = pos_r; plen_nxt = '0; wpre_nxt = '0;
          end
        end
        tlex_pkg::C_BLANK: ;
        default: begin
          pst_nxt = pos_r; plen_nxt = 17'd1; wpre_nxt = '0;
          case (cls)
            tlex_pkg::C_EQ:    mode_nxt = tlex_pkg::M_EQ;
            tlex_pkg::C_BANG:  mode_nxt = tlex_pkg::M_BANG;
            tlex_pkg::C_DQ:    mode_nxt = tlex_pkg::M_DQ;
            tlex_pkg::C_SQ:    mode_nxt = tlex_pkg::M_SQ;
            tlex_pkg::C_DIGIT: mode_nxt = tlex_pkg::M_NUM;
            default: begin mode_nxt = tlex_pkg::M_WORD; wpre_nxt = {32'h0, c}; end
          endcase
        end
      endcase
    end

    if (n_tok == 2'd1) t0.last = 1'b1;
    if (n_tok == 2'd2) t1.last = 1'b1;

    // End of text resets scanner; otherwise advance offset
    if (cls == tlex_pkg::C_ZERO && (mode_r == tlex_pkg::M_DROP || mode_nxt != tlex_pkg::M_DROP))
    begin
      mode_nxt = tlex_pkg::M_IDLE; pos_nxt = '0; pst_nxt = '0; plen_nxt = '0; wpre_nxt = '0;
    end else begin
      pos_nxt = (pos_inc >= (tlex_pkg::PosW+1)'(tlex_pkg::LenCap)) ? '0
                : pos_inc[tlex_pkg::PosW-1:0];
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tlex_pkg::M_IDLE; pos_r <= '0; pst_r <= '0; plen_r <= '0; wpre_r <= '0;
    end else if (adv) begin
      mode_r <= mode_nxt; pos_r <= pos_nxt; pst_r <= pst_nxt;
      plen_r <= plen_nxt; wpre_r <= wpre_nxt;
    end
  end

  // Output slots: s0 is shown, s1 holds a second token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0;
    end else if (adv) begin
      v0_r <= (n_tok != 2'd0); v1_r <= (n_tok == 2'd2);
      s0_r <= t0; s1_r <= t1;
    end else if (v0_r && out_ready) begin
      v0_r <= v1_r; v1_r <= 1'b0; s0_r <= s1_r;
    end
  end

  assign out_valid = v0_r;
  assign out_tok   = s0_r;

  property p_slot_order;
    @(posedge clk) disable iff (!rst_n) v1_r |-> v0_r;
  endproperty
  a_slot_order: assert property (p_slot_order) else $error("second slot without first");

  property p_hold;
    @(posedge clk) disable iff (!rst_n) (v0_r && !out_ready) |=> (v0_r && $stable(s0_r));
  endproperty
  a_hold: assert property (p_hold) else $error("pending token lost");

  property p_end_reset;
    @(posedge clk) disable iff (!rst_n)
      (adv && cls == tlex_pkg::C_ZERO) |=> (pos_r == '0 && mode_r == tlex_pkg::M_IDLE);
  endproperty
  a_end_reset: assert property (p_end_reset) else $error("end of text did not restart");

endmodule

[design/token_lexer_top.sv]
// Token lexer: one character in per cycle while the queue has room, tokens out through a two-slot buffer.
// A character is registered in the queue; its token is registered in an output slot when the back part takes it.
// Throughput: one character per cycle while the queue has room; a character that gives two tokens holds the
// back part while the second token drains, and the 4-word queue absorbs the stall.
// Reset: synchronous active-low; scanner idle at offset zero, queue and buffer empty.
module token_lexer_top (
  input  logic clk,
  input  logic rst_n,
  tlex_if.sink   in_ch,
  tlex_if.source out_ch
);

  logic q_push, q_full, q_avail, q_pop;
  tlex_pkg::qword_t q_in, q_head;
  tlex_pkg::tok_t   tok;

  tlex_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_text_char(in_ch.data), .q_push(q_push), .q_data(q_in), .q_full(q_full)
  );

  tlex_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
    .avail(q_avail), .head(q_head), .pop(q_pop)
  );

  tlex_back u_back (
    .clk(clk), .rst_n(rst_n), .q_avail(q_avail), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_tok(tok)
  );

  assign out_ch.data = tok;

endmodule

[verif/tb_token_lexer_top.sv]
// Self-checking testbench for the token lexer: random and directed text, token scoreboard.
`timescale 1ns / 1ps

module tb_token_lexer_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlex_if #(.T(logic [7:0]))       in_if ();
  tlex_if #(.T(tlex_pkg::tok_t))   out_if ();

  token_lexer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  always #5 clk = ~clk;

  logic [7:0]      text_q[$];
  tlex_pkg::tok_t  token_exp_q[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         error_count = 0;
  int         chars_sent = 0;
  int         tokens_seen = 0;

  // Scanner state mirrored by the predictor
  tlex_pkg::scan_mode_t          lx_mode = tlex_pkg::M_IDLE;
  logic [tlex_pkg::PosW-1:0]     lx_pos = '0;
  logic [tlex_pkg::PosW-1:0]     lx_start = '0;
  logic [tlex_pkg::LenW-1:0]     lx_len = '0;
  logic [39:0]                   lx_prefix = '0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [tlex_pkg::LenW-1:0] len_bump(input logic [tlex_pkg::LenW-1:0] n);
    return (n < tlex_pkg::LenCap) ? n + 1'b1 : n;
  endfunction

  function automatic tlex_pkg::kind_t keyword_kind(input logic [tlex_pkg::LenW-1:0] n,
                                                   input logic [39:0] w);
    if (n == 3 && w == 40'h696E74)     return tlex_pkg::K_INT;
    if (n == 4 && w == 40'h6C6F6E67)   return tlex_pkg::K_LONG;
    if (n == 4 && w == 40'h626F6F6C)   return tlex_pkg::K_BOOL;
    if (n == 4 && w == 40'h63686172)   return tlex_pkg::K_CHAR;
    if (n == 3 && w == 40'h737472)     return tlex_pkg::K_STR;
    if (n == 4 && w == 40'h74727565)   return tlex_pkg::K_TRUE;
    if (n == 5 && w == 40'h66616C7365) return tlex_pkg::K_FALSE;
    return tlex_pkg::K_IDENT;
  endfunction

  task automatic push_token(input tlex_pkg::kind_t k, input logic [tlex_pkg::PosW-1:0] s,
                            input logic [tlex_pkg::LenW-1:0] l);
    tlex_pkg::tok_t t;
    t.kind = k;
    t.start = s;
    t.len = l;
    t.last = 1'b0;
    token_exp_q.push_back(t);
  endtask

  // Advance the mirrored scanner by one character and queue the tokens it ends
  task automatic lex_char(input logic [7:0] c);
    int               n0;
    bit               fall;
    tlex_pkg::kind_t  k;
    tlex_pkg::tok_t   t;
    n0 = token_exp_q.size();
    fall = 1'b0;
    case (lx_mode)
      tlex_pkg::M_DROP: begin
        if (c == 8'h00) begin
          lx_mode = tlex_pkg::M_IDLE; lx_pos = '0; lx_start = '0; lx_len = '0;
          lx_prefix = '0;
        end else begin
          lx_pos = lx_pos + 1'b1;
        end
        return;
      end
      tlex_pkg::M_DQ, tlex_pkg::M_SQ: begin
        k = (lx_mode == tlex_pkg::M_DQ) ? tlex_pkg::K_DQSTR : tlex_pkg::K_SQSTR;
        if (c == ((lx_mode == tlex_pkg::M_DQ) ? 8'h22 : 8'h27)) begin
          push_token(k, lx_start, len_bump(lx_len));
          lx_mode = tlex_pkg::M_IDLE;
        end else if (c == 8'h00) begin
          push_token(k, lx_start, lx_len);
          push_token(tlex_pkg::K_END, lx_pos, 17'd1);
        end else begin
          lx_len = len_bump(lx_len);
        end
      end
      tlex_pkg::M_NUM: begin
        if (is_digit(c)) lx_len = len_bump(lx_len);
        else begin
          push_token(tlex_pkg::K_NUMBER, lx_start, lx_len);
          fall = 1'b1;
        end
      end
      tlex_pkg::M_WORD: begin
        if (is_digit(c) || is_alpha(c)) begin
          if (lx_len < 5) lx_prefix = {lx_prefix[31:0], c};
          lx_len = len_bump(lx_len);
        end else begin
          push_token(keyword_kind(lx_len, lx_prefix), lx_start, lx_len);
          fall = 1'b1;
        end
      end
      tlex_pkg::M_EQ, tlex_pkg::M_BANG: begin
        if (c == "=") begin
          push_token((lx_mode == tlex_pkg::M_EQ) ? tlex_pkg::K_EQEQ : tlex_pkg::K_NE,
                     lx_start, 17'd2);
          lx_mode = tlex_pkg::M_IDLE;
        end else begin
          push_token((lx_mode == tlex_pkg::M_EQ) ? tlex_pkg::K_ASSIGN : tlex_pkg::K_NOT,
                     lx_start, 17'd1);
          fall = 1'b1;
        end
      end
      default: fall = 1'b1;
    endcase

    // Scan the character afresh from idle
    if (fall) begin
      lx_mode = tlex_pkg::M_IDLE;
      if (c == 8'h00) push_token(tlex_pkg::K_END, lx_pos, 17'd1);
      else if (c == " " || c == 8'h0A || c == 8'h09 || c == 8'h0D) begin
      end else if (tlex_pkg::punct_kind(c) != tlex_pkg::K_END)
        push_token(tlex_pkg::punct_kind(c), lx_pos, 17'd1);
      else begin
        lx_start = lx_pos;
        lx_len = 17'd1;
        lx_prefix = '0;
        if (c == "=") lx_mode = tlex_pkg::M_EQ;
        else if (c == "!") lx_mode = tlex_pkg::M_BANG;
        else if (c == 8'h22) lx_mode = tlex_pkg::M_DQ;
        else if (c == 8'h27) lx_mode = tlex_pkg::M_SQ;
        else if (is_digit(c)) lx_mode = tlex_pkg::M_NUM;
        else if (is_alpha(c)) begin
          lx_mode = tlex_pkg::M_WORD;
          lx_prefix = {32'h0, c};
        end else begin
          lx_len = '0;
          lx_mode = tlex_pkg::M_DROP;
          push_token(tlex_pkg::K_ERROR, lx_pos, 17'd1);
        end
      end
    end

    if (c == 8'h00 && lx_mode != tlex_pkg::M_DROP) begin
      lx_mode = tlex_pkg::M_IDLE; lx_pos = '0; lx_start = '0; lx_len = '0; lx_prefix = '0;
    end else begin
      lx_pos = lx_pos + 1'b1;
    end
    if (token_exp_q.size() > n0) begin
      t = token_exp_q[$];
      t.last = 1'b1;
      token_exp_q[token_exp_q.size()-1] = t;
    end
  endtask

  // Driver: present the next character when the channel is free
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.data <= text_q[0];
        in_if.valid <= 1'b1;
        lex_char(text_q.pop_front());
        chars_sent++;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: randomize ready and check each accepted token word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        tokens_seen++;
        if (token_exp_q.size() == 0) begin
          $display("%0t: unexpected token kind=%0d start=%0d len=%0d last=%0b", $time,
                   out_if.data.kind, out_if.data.start, out_if.data.len, out_if.data.last);
          error_count++;
        end else begin
          if (out_if.data !== token_exp_q[0]) begin
            $display("%0t: token mismatch expected kind=%0d start=%0d len=%0d last=%0b",
                     $time, token_exp_q[0].kind, token_exp_q[0].start, token_exp_q[0].len,
                     token_exp_q[0].last);
            $display("%0t:                actual kind=%0d start=%0d len=%0d last=%0b",
                     $time, out_if.data.kind, out_if.data.start, out_if.data.len,
                     out_if.data.last);
            error_count++;
          end
          void'(token_exp_q.pop_front());
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Build one random text: mostly well-formed tokens, some noise, ended by a zero byte
  task automatic add_random_text();
    string words[10] = '{"int", "long", "bool", "char", "str", "true", "false",
                         "intx", "falsey", "st"};
    string puncts = ",;{}[]()+-%*/";
    string blanks = " \t\r\n";
    int    ntok;
    int    sel;
    logic [7:0] q;
    logic [7:0] b;
    ntok = $urandom_range(1, 10);
    for (int i = 0; i < ntok; i++) begin
      sel = $urandom_range(99);
      if (sel < 15) text_q.push_back(puncts[$urandom_range(12)]);
      else if (sel < 25) begin
        text_q.push_back($urandom_range(1) ? "=" : "!");
        if ($urandom_range(1)) text_q.push_back("=");
      end else if (sel < 40) begin
        q = $urandom_range(1) ? 8'h22 : 8'h27;
        text_q.push_back(q);
        repeat ($urandom_range(0, 6)) begin
          do b = 8'($urandom_range(1, 255)); while (b == q);
          text_q.push_back(b);
        end
        // leave a few strings open up to the end of text
        if ($urandom_range(19) == 0) break;
        text_q.push_back(q);
      end else if (sel < 52) begin
        repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range("0", "9")));
      end else if (sel < 70) add_str(words[$urandom_range(9)]);
      else if (sel < 88) begin
        text_q.push_back(8'($urandom_range(1) ? $urandom_range("a", "z")
                                              : $urandom_range("A", "Z")));
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(2))
            0: text_q.push_back(8'($urandom_range("a", "z")));
            1: text_q.push_back(8'($urandom_range("A", "Z")));
            default: text_q.push_back(8'($urandom_range("0", "9")));
          endcase
        end
      end else if (sel < 94) text_q.push_back(8'($urandom_range(1, 255)));
      else text_q.push_back(8'($urandom_range(1) ? 32'h23 : $urandom_range(128, 255)));
      if ($urandom_range(2) != 0) text_q.push_back(blanks[$urandom_range(3)]);
    end
    text_q.push_back(8'h00);
  endtask

  task automatic wait_drained();
    while (text_q.size() > 0 || in_if.valid || token_exp_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int pend;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every kind, keyword near misses, blanks, strings, errors
    add_str("int long bool char str true false intx x1 falsey");
    text_q.push_back(8'h00);
    add_str(",;{}[]()+-%*/ == = != ! =!a!=b==c");
    text_q.push_back(8'h09); text_q.push_back(8'h0D); text_q.push_back(8'h0A);
    text_q.push_back(8'h22); add_str("a b"); text_q.push_back(8'h22);
    text_q.push_back(8'h27); text_q.push_back(8'hFF); text_q.push_back(8'h27);
    add_str("0123456789 9");
    text_q.push_back(8'h00);
    text_q.push_back(8'h00);
    add_str("ab"); text_q.push_back(8'h80); add_str("cd 1"); text_q.push_back(8'h00);
    text_q.push_back(8'h22); add_str("open"); text_q.push_back(8'h00);
    text_q.push_back(8'h27); text_q.push_back(8'h00);
    add_str("="); text_q.push_back(8'h00);
    add_str("!"); text_q.push_back(8'h00);
    add_str("12"); text_q.push_back(8'h00);
    add_str("x"); text_q.push_back(8'h00);
    text_q.push_back(8'h7F); text_q.push_back(8'h00);
    wait_drained();

    // Random phases with different idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      pend = 0;
      while (pend < 170) begin
        pend -= text_q.size();
        add_random_text();
        pend += text_q.size();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d characters over four idle/stall phases, checked %0d tokens.",
             chars_sent, tokens_seen);
    if (error_count == 0 && token_exp_q.size() == 0) begin
      $display("token_lexer_top verification clean");
    end else begin
      $display("token_lexer_top verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20ms;
    $display("token_lexer_top verification failed");
    $finish;
  end

endmodule
